>>> sv/pqg_pkg.sv
package pqg_pkg;

   // word format
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int FieldWidth = 32;

   // inner segments have |x| <= 5.0, so a narrow copy of x suffices there
   localparam int XW   = FRAC_BITS + 4;
   localparam int CW   = FRAC_BITS + 2;
   localparam int SQW  = 2 * XW - FRAC_BITS;
   localparam int LTW  = XW + CW - FRAC_BITS;
   localparam int QTW  = SQW + CW - FRAC_BITS;
   localparam int LSW  = ((LTW > CW) ? LTW : CW) + 1;
   localparam int SUMW = ((QTW > LSW) ? QTW : LSW) + 1;
   localparam int SATW = (SUMW > DATA_WIDTH) ? SUMW : DATA_WIDTH;

   // segment codes
   localparam int SEG_W = 3;
   localparam int NumSegments = 6;
   localparam int NumBreaks = 5;
   localparam logic [SEG_W-1:0] SEG_FLOOR   = 3'd0;
   localparam logic [SEG_W-1:0] SEG_NEG_FAR = 3'd1;
   localparam logic [SEG_W-1:0] SEG_NEG_MID = 3'd2;
   localparam logic [SEG_W-1:0] SEG_CENTRE  = 3'd3;
   localparam logic [SEG_W-1:0] SEG_POS_MID = 3'd4;
   localparam logic [SEG_W-1:0] SEG_PASS    = 3'd5;

   // coefficient indexes within a row
   localparam int CoefConst = 0;
   localparam int CoefLin   = 1;
   localparam int CoefQuad  = 2;

   localparam longint DecScale = 64'd100000000;
   localparam longint DecDiv   = 2 * DecScale;
   localparam longint QScale   = longint'(1) <<< (FRAC_BITS + 1);

   // breakpoints -5, -3, -1, 1, 3 in fixed point
   localparam logic signed [DATA_WIDTH-1:0] BREAK_POINT [NumBreaks] = '{
      DATA_WIDTH'(-64'sd5 * (64'sd1 <<< FRAC_BITS)),
      DATA_WIDTH'(-64'sd3 * (64'sd1 <<< FRAC_BITS)),
      DATA_WIDTH'(-64'sd1 * (64'sd1 <<< FRAC_BITS)),
      DATA_WIDTH'( 64'sd1 * (64'sd1 <<< FRAC_BITS)),
      DATA_WIDTH'( 64'sd3 * (64'sd1 <<< FRAC_BITS))
   };

   // constant, linear and quadratic coefficients in fixed point: decimal values
   // scaled by 10^8, rounded to nearest with ties away from zero
   localparam logic signed [CW-1:0] COEF_Q [NumSegments][3] = '{
      '{CW'(0), CW'(0), CW'(0)},
      '{CW'(-((2986296 * QScale + DecScale) / DecDiv)),
        CW'(-((1380208 * QScale + DecScale) / DecDiv)),
        CW'(-((158297 * QScale + DecScale) / DecDiv))},
      '{CW'(-((36497047 * QScale + DecScale) / DecDiv)),
        CW'(-((23581369 * QScale + DecScale) / DecDiv)),
        CW'(-((3840320 * QScale + DecScale) / DecDiv))},
      '{CW'((485947 * QScale + DecScale) / DecDiv),
        CW'((50000716 * QScale + DecScale) / DecDiv),
        CW'((34826040 * QScale + DecScale) / DecDiv)},
      '{CW'(-((36491015 * QScale + DecScale) / DecDiv)),
        CW'((123575599 * QScale + DecScale) / DecDiv),
        CW'(-((3839009 * QScale + DecScale) / DecDiv))},
      '{CW'(0), CW'((100000000 * QScale + DecScale) / DecDiv), CW'(0)}
   };

   typedef struct packed {
      logic             valid;
      logic [SEG_W-1:0] seg;
   } tag_type;

   function automatic logic signed [CW-1:0] coef(input logic [SEG_W-1:0] seg,
                                                 input int k);
      logic signed [CW-1:0] c;
      c = '0;
      case (seg)
         SEG_NEG_FAR: c = COEF_Q[1][k];
         SEG_NEG_MID: c = COEF_Q[2][k];
         SEG_CENTRE:  c = COEF_Q[3][k];
         SEG_POS_MID: c = COEF_Q[4][k];
         default:     c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> sv/pqg_segment.sv
module pqg_segment
   import pqg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [FieldWidth-1:0]        req_x,
   output tag_type                      tag,
   output logic signed [DATA_WIDTH-1:0] x
);

   tag_type                      tag_ff, tag_in;
   logic signed [DATA_WIDTH-1:0] x_ff, x_in;
   logic [NumBreaks-1:0]         above;

   // compare against every breakpoint, strict so equality drops to the lower segment
   always_comb begin
      x_in = DATA_WIDTH'(signed'(req_x[DATA_WIDTH-1:0]));
      for (int i = 0; i < NumBreaks; i++) begin
         above[i] = BREAK_POINT[i] < x_in;
      end
      tag_in.valid = start;
      tag_in.seg   = SEG_W'($countones(above));
   end

   // advance the valid bit, hold the word
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in.valid;
      end
      tag_ff.seg <= tag_in.seg;
      x_ff       <= x_in;
   end

   assign tag = tag_ff;
   assign x   = x_ff;

endmodule

>>> sv/pqg_product.sv
module pqg_product
   import pqg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  tag_type                      tag,
   input  logic signed [DATA_WIDTH-1:0] x,
   output tag_type                      tag_out,
   output logic signed [DATA_WIDTH-1:0] x_out,
   output logic signed [QTW-1:0]        qt,
   output logic signed [LSW-1:0]        lsum
);

   // square and linear stage
   tag_type                      tag2_ff;
   logic signed [DATA_WIDTH-1:0] x2_ff;
   logic signed [SQW-1:0]        sq2_ff, sq2_in;
   logic signed [LTW-1:0]        lt2_ff, lt2_in;
   logic signed [CW-1:0]         c0_2_ff, c0_2_in;
   logic signed [CW-1:0]         c2_2_ff, c2_2_in;
   logic signed [XW-1:0]         xn;
   logic signed [CW-1:0]         c1;
   logic signed [2*XW-1:0]       sq_prod;
   logic signed [XW+CW-1:0]      lt_prod;

   // quadratic stage
   tag_type                      tag3_ff;
   logic signed [DATA_WIDTH-1:0] x3_ff;
   logic signed [QTW-1:0]        qt3_ff, qt3_in;
   logic signed [LSW-1:0]        ls3_ff, ls3_in;
   logic signed [SQW+CW-1:0]     qt_prod;

   // form x*x and c1*x from the narrow copy, pick the segment's coefficients
   always_comb begin
      xn      = x[XW-1:0];
      c1      = coef(tag.seg, CoefLin);
      c0_2_in = coef(tag.seg, CoefConst);
      c2_2_in = coef(tag.seg, CoefQuad);
      sq_prod = xn * xn;
      lt_prod = xn * c1;
      sq2_in  = SQW'(sq_prod >>> FRAC_BITS);
      lt2_in  = LTW'(lt_prod >>> FRAC_BITS);
   end

   // form c2*sq and fold the constant into the linear term
   always_comb begin
      qt_prod = sq2_ff * c2_2_ff;
      qt3_in  = QTW'(qt_prod >>> FRAC_BITS);
      ls3_in  = LSW'(lt2_ff) + LSW'(c0_2_ff);
   end

   // advance valid bits, hold the words
   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
      end else begin
         tag2_ff.valid <= tag.valid;
         tag3_ff.valid <= tag2_ff.valid;
      end
      tag2_ff.seg <= tag.seg;
      x2_ff       <= x;
      sq2_ff      <= sq2_in;
      lt2_ff      <= lt2_in;
      c0_2_ff     <= c0_2_in;
      c2_2_ff     <= c2_2_in;
      tag3_ff.seg <= tag2_ff.seg;
      x3_ff       <= x2_ff;
      qt3_ff      <= qt3_in;
      ls3_ff      <= ls3_in;
   end

   assign tag_out = tag3_ff;
   assign x_out   = x3_ff;
   assign qt      = qt3_ff;
   assign lsum    = ls3_ff;

endmodule

>>> sv/pqg_output.sv
module pqg_output
   import pqg_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  tag_type                      tag,
   input  logic signed [DATA_WIDTH-1:0] x,
   input  logic signed [QTW-1:0]        qt,
   input  logic signed [LSW-1:0]        lsum,
   output logic                         rsp_valid,
   output logic [FieldWidth-1:0]        rsp_y,
   output logic [SEG_W-1:0]             rsp_segment
);

   localparam logic signed [SATW-1:0] YMax = SATW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam logic signed [SATW-1:0] YMin = -YMax - SATW'(1);

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] y_ff, y_in;
   logic [SEG_W-1:0]      seg_ff;
   logic signed [SATW-1:0] y_wide;

   // add the terms, take the outer segments straight, then saturate
   always_comb begin
      case (tag.seg)
         SEG_FLOOR: y_wide = '0;
         SEG_PASS:  y_wide = SATW'(x);
         default:   y_wide = SATW'(SUMW'(qt) + SUMW'(lsum));
      endcase
      if (y_wide > YMax) begin
         y_in = DATA_WIDTH'(YMax);
      end else if (y_wide < YMin) begin
         y_in = DATA_WIDTH'(YMin);
      end else begin
         y_in = DATA_WIDTH'(y_wide);
      end
   end

   // strobe the result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag.valid;
      end
   end

   // hold the result word
   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      seg_ff <= tag.seg;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_y       = FieldWidth'(y_ff);
   assign rsp_segment = seg_ff;

endmodule

>>> sv/piecewise_quadratic_gelu_unit.sv
// Six-segment piecewise-quadratic GeLU, one signed fixed-point sample per
// clock. A word is taken at each rising edge with start high; busy is tied
// low, so a new word may follow every cycle with no gaps. The result (y and
// the segment index) is shown on the rsp_ ports for one cycle under
// rsp_valid, once the word has passed through the register stages: one stage
// of breakpoint compares, one for x*x and c1*x, one for c2*x^2, and one to
// add, saturate and register. The receiver cannot hold results off and needs
// none of that, since one result leaves for every word taken, in order.
module piecewise_quadratic_gelu_unit
   import pqg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FieldWidth-1:0] req_x,
   output logic                  rsp_valid,
   output logic [FieldWidth-1:0] rsp_y,
   output logic [SEG_W-1:0]      rsp_segment
);

   tag_type                      s1_tag;
   logic signed [DATA_WIDTH-1:0] s1_x;
   tag_type                      s3_tag;
   logic signed [DATA_WIDTH-1:0] s3_x;
   logic signed [QTW-1:0]        s3_qt;
   logic signed [LSW-1:0]        s3_lsum;

   // the pipeline never stalls
   assign busy = 1'b0;

   pqg_segment u_segment (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req_x (req_x),
      .tag   (s1_tag),
      .x     (s1_x)
   );

   pqg_product u_product (
      .clock   (clock),
      .reset   (reset),
      .tag     (s1_tag),
      .x       (s1_x),
      .tag_out (s3_tag),
      .x_out   (s3_x),
      .qt      (s3_qt),
      .lsum    (s3_lsum)
   );

   pqg_output u_output (
      .clock       (clock),
      .reset       (reset),
      .tag         (s3_tag),
      .x           (s3_x),
      .qt          (s3_qt),
      .lsum        (s3_lsum),
      .rsp_valid   (rsp_valid),
      .rsp_y       (rsp_y),
      .rsp_segment (rsp_segment)
   );

endmodule
